FILE: rtl/core/ari_pkg.sv
// ----------------------------------------------------------------------------
// ari_pkg
// Shared types and constants of the adjusted Rand index engine.
// ----------------------------------------------------------------------------
package ari_pkg;

  // defaults of the top-level parameters
  localparam int unsigned MaxClustersDef  = 64;
  localparam int unsigned CountBitsDef    = 16;
  localparam int unsigned FractionBitsDef = 30;

  // configuration registers
  localparam int unsigned CfgW       = 7;
  localparam int unsigned CfgResetV  = 64;
  localparam int unsigned RegRows    = 0;
  localparam int unsigned RegCols    = 1;
  localparam int unsigned PaddrW     = 3;
  localparam int unsigned PdataW     = 32;

  // result
  localparam int unsigned OutW = 32;
  localparam int unsigned QuoW = 34;  // quotient register, saturates at 2^33

  typedef enum logic [1:0] {
    MUL_IT = 2'd0,  // cell pairs x total pairs
    MUL_RC = 2'd1,  // row pairs x column pairs
    MUL_PT = 2'd2   // (row + column pairs) x total pairs
  } mul_sel_e;

  typedef struct packed {
    logic     cell_en;    // accept a cell
    logic     row_end;    // fold the row total into the row pair sum
    logic     walk_sel;   // column store read address from the counter
    logic     walk_clr;   // clear the column pair sum
    logic     walk_acc;   // add the pairs of the column just read
    logic     cnt_clr;
    logic     cnt_inc;
    logic     tot;        // pairs of the grand total
    logic     mul_load;
    logic     mul_step;
    logic     mul_store;
    mul_sel_e mul_sel;
    logic     prep;       // numerator, denominator, sign
    logic     div_load;
    logic     div_step;
    logic     finish;     // load the result, clear the table state
  } ari_cmd_t;

  typedef struct packed {
    logic col_last;
    logic row_last;
    logic walk_last;
    logic mul_last;
    logic div_last;
    logic undef;
    logic out_busy;
  } ari_sts_t;

endpackage

FILE: rtl/core/ari_ctrl.sv
// ----------------------------------------------------------------------------
// ari_ctrl
// Sequencer: cell intake, row close, column walk, products, division, result.
// ----------------------------------------------------------------------------
module ari_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ari_pkg::ari_sts_t sts_i,
  output ari_pkg::ari_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ROW      = 4'd1;
  localparam logic [3:0] S_WALK_RD  = 4'd2;
  localparam logic [3:0] S_WALK_ACC = 4'd3;
  localparam logic [3:0] S_TOT      = 4'd4;
  localparam logic [3:0] S_MUL_LD   = 4'd5;
  localparam logic [3:0] S_MUL_RUN  = 4'd6;
  localparam logic [3:0] S_MUL_ST   = 4'd7;
  localparam logic [3:0] S_PREP     = 4'd8;
  localparam logic [3:0] S_CHECK    = 4'd9;
  localparam logic [3:0] S_DIV_RUN  = 4'd10;
  localparam logic [3:0] S_OUT      = 4'd11;

  logic [3:0]        state_q, state_d;
  ari_pkg::mul_sel_e sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= ari_pkg::MUL_IT;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    sel_d         = sel_q;
    cmd_o         = '0;
    cmd_o.mul_sel = sel_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.cell_en = in_valid_i;
        if (in_valid_i && sts_i.col_last) state_d = S_ROW;
      end
      S_ROW: begin
        cmd_o.row_end = 1'b1;
        if (sts_i.row_last) begin
          cmd_o.cnt_clr  = 1'b1;
          cmd_o.walk_clr = 1'b1;
          state_d        = S_WALK_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WALK_RD: begin
        cmd_o.walk_sel = 1'b1;
        state_d        = S_WALK_ACC;
      end
      S_WALK_ACC: begin
        cmd_o.walk_acc = 1'b1;
        if (sts_i.walk_last) begin
          state_d = S_TOT;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_WALK_RD;
        end
      end
      S_TOT: begin
        cmd_o.tot = 1'b1;
        sel_d     = ari_pkg::MUL_IT;
        state_d   = S_MUL_LD;
      end
      S_MUL_LD: begin
        cmd_o.mul_load = 1'b1;
        cmd_o.cnt_clr  = 1'b1;
        state_d        = S_MUL_RUN;
      end
      S_MUL_RUN: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        if (sts_i.mul_last) state_d = S_MUL_ST;
      end
      S_MUL_ST: begin
        cmd_o.mul_store = 1'b1;
        case (sel_q)
          ari_pkg::MUL_IT: begin
            sel_d   = ari_pkg::MUL_RC;
            state_d = S_MUL_LD;
          end
          ari_pkg::MUL_RC: begin
            sel_d   = ari_pkg::MUL_PT;
            state_d = S_MUL_LD;
          end
          default: begin
            state_d = S_PREP;
          end
        endcase
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.undef) begin
          state_d = S_OUT;
        end else begin
          cmd_o.div_load = 1'b1;
          cmd_o.cnt_clr  = 1'b1;
          state_d        = S_DIV_RUN;
        end
      end
      S_DIV_RUN: begin
        cmd_o.div_step = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        if (sts_i.div_last) state_d = S_OUT;
      end
      S_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/ari_dp.sv
// ----------------------------------------------------------------------------
// ari_dp
// Datapath: running sums, column store, serial multiplier, restoring divider,
// result register.
// ----------------------------------------------------------------------------
module ari_dp #(
  parameter int unsigned MAX_CLUSTERS  = ari_pkg::MaxClustersDef,
  parameter int unsigned COUNT_BITS    = ari_pkg::CountBitsDef,
  parameter int unsigned FRACTION_BITS = ari_pkg::FractionBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ari_pkg::ari_cmd_t          cmd_i,
  output ari_pkg::ari_sts_t          sts_o,
  input  logic [COUNT_BITS-1:0]      cell_count_i,
  input  logic [ari_pkg::CfgW-1:0]   rows_i,
  input  logic [ari_pkg::CfgW-1:0]   cols_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ari_pkg::OutW-1:0]   index_value_o,
  output logic                       undefined_flag_o
);

  localparam int unsigned PB    = $clog2(MAX_CLUSTERS);
  localparam int unsigned NW    = PB + 1;
  localparam int unsigned CB    = COUNT_BITS;
  localparam int unsigned SW    = CB + PB;
  localparam int unsigned TW    = CB + 2 * PB;
  localparam int unsigned AW    = 2 * TW;
  localparam int unsigned PW    = 2 * AW;
  localparam int unsigned DW    = PW + 1;
  localparam int unsigned RW    = DW + 1;
  localparam int unsigned XW    = DW + FRACTION_BITS;
  localparam int unsigned ITERS = DW + FRACTION_BITS;
  localparam int unsigned CW    = $clog2(ITERS + MAX_CLUSTERS + 1);
  localparam int unsigned EW    = ari_pkg::CfgW + NW;
  localparam int unsigned QW    = ari_pkg::QuoW;
  localparam int unsigned OW    = ari_pkg::OutW;

  // ---------------- register clamps ----------------
  logic [EW-1:0] rows_x, cols_x;
  logic [NW-1:0] nrows, ncols;

  assign rows_x = EW'(rows_i);
  assign cols_x = EW'(cols_i);

  always_comb begin
    if (rows_x == '0)                      nrows = NW'(1);
    else if (rows_x > EW'(MAX_CLUSTERS))   nrows = NW'(MAX_CLUSTERS);
    else                                   nrows = rows_x[NW-1:0];
    if (cols_x == '0)                      ncols = NW'(1);
    else if (cols_x > EW'(MAX_CLUSTERS))   ncols = NW'(MAX_CLUSTERS);
    else                                   ncols = cols_x[NW-1:0];
  end

  // ---------------- positions and counter ----------------
  logic [PB-1:0] col_pos_q, col_pos_d, row_pos_q;
  logic [CW-1:0] cnt_q;
  logic          col_last, row_last;

  assign col_last = ({1'b0, col_pos_q} + NW'(1)) >= ncols;
  assign row_last = ({1'b0, row_pos_q} + NW'(1)) >= nrows;

  always_comb begin
    col_pos_d = col_pos_q;
    if (cmd_i.cell_en) col_pos_d = col_last ? '0 : col_pos_q + PB'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q <= '0;
      row_pos_q <= '0;
      cnt_q     <= '0;
    end else begin
      col_pos_q <= col_pos_d;
      if (cmd_i.row_end) row_pos_q <= row_last ? '0 : row_pos_q + PB'(1);
      if (cmd_i.cnt_clr)      cnt_q <= '0;
      else if (cmd_i.cnt_inc) cnt_q <= cnt_q + CW'(1);
    end
  end

  // ---------------- column store ----------------
  logic [SW-1:0]           mem_q [MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0] ent_valid_q;
  logic [PB-1:0]           rd_addr;
  logic [SW-1:0]           rdata_q, wr_data_q, col_cur, col_new, walk_d;
  logic                    rvalid_q, wr_hit_q;

  assign rd_addr = cmd_i.walk_sel ? cnt_q[PB-1:0] : col_pos_d;
  assign walk_d  = rvalid_q ? rdata_q : '0;
  // a write to the address read in the same cycle is forwarded
  assign col_cur = wr_hit_q ? wr_data_q : walk_d;
  assign col_new = col_cur + SW'(cell_count_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cell_en) mem_q[col_pos_q] <= col_new;
    rdata_q   <= mem_q[rd_addr];
    wr_data_q <= col_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
      rvalid_q    <= 1'b0;
      wr_hit_q    <= 1'b0;
    end else begin
      if (cmd_i.finish)       ent_valid_q <= '0;
      else if (cmd_i.cell_en) ent_valid_q[col_pos_q] <= 1'b1;
      rvalid_q <= ent_valid_q[rd_addr] && !cmd_i.finish;
      wr_hit_q <= cmd_i.cell_en && (col_pos_q == rd_addr);
    end
  end

  // ---------------- running sums ----------------
  logic [SW-1:0]   row_acc_q;
  logic [TW-1:0]   total_q;
  logic [AW-1:0]   cell_ps_q, row_ps_q, col_ps_q, tot_ps_q;
  logic [2*CB-1:0] v_prod;
  logic [SW-1:0]   sw_op;
  logic [2*SW-1:0] sw_prod;
  logic [2*TW-1:0] t_prod;

  // n(n-1) is zero for n = 0 as well
  assign v_prod  = cell_count_i * (cell_count_i - CB'(1));
  assign sw_op   = cmd_i.row_end ? row_acc_q : walk_d;
  assign sw_prod = sw_op * (sw_op - SW'(1));
  assign t_prod  = total_q * (total_q - TW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_acc_q <= '0;
      total_q   <= '0;
      cell_ps_q <= '0;
      row_ps_q  <= '0;
      col_ps_q  <= '0;
      tot_ps_q  <= '0;
    end else begin
      if (cmd_i.cell_en) begin
        row_acc_q <= row_acc_q + SW'(cell_count_i);
        total_q   <= total_q + TW'(cell_count_i);
        cell_ps_q <= cell_ps_q + AW'(v_prod[2*CB-1:1]);
      end
      if (cmd_i.row_end) begin
        row_ps_q  <= row_ps_q + AW'(sw_prod[2*SW-1:1]);
        row_acc_q <= '0;
      end
      if (cmd_i.walk_clr)      col_ps_q <= '0;
      else if (cmd_i.walk_acc) col_ps_q <= col_ps_q + AW'(sw_prod[2*SW-1:1]);
      if (cmd_i.tot) tot_ps_q <= AW'(t_prod[2*TW-1:1]);
      if (cmd_i.finish) begin
        row_acc_q <= '0;
        total_q   <= '0;
        cell_ps_q <= '0;
        row_ps_q  <= '0;
        col_ps_q  <= '0;
      end
    end
  end

  // ---------------- serial multiplier, one bit a cycle ----------------
  logic [DW-1:0] mc_q, acc_q, p_q;
  logic [AW-1:0] ml_q;
  logic [PW-1:0] a_q, b_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      acc_q <= '0;
      case (cmd_i.mul_sel)
        ari_pkg::MUL_IT: begin
          mc_q <= DW'(cell_ps_q);
          ml_q <= tot_ps_q;
        end
        ari_pkg::MUL_RC: begin
          mc_q <= DW'(row_ps_q);
          ml_q <= col_ps_q;
        end
        default: begin
          mc_q <= DW'(row_ps_q) + DW'(col_ps_q);
          ml_q <= tot_ps_q;
        end
      endcase
    end else if (cmd_i.mul_step) begin
      if (ml_q[0]) acc_q <= acc_q + mc_q;
      mc_q <= {mc_q[DW-2:0], 1'b0};
      ml_q <= {1'b0, ml_q[AW-1:1]};
    end
    if (cmd_i.mul_store) begin
      case (cmd_i.mul_sel)
        ari_pkg::MUL_IT: a_q <= acc_q[PW-1:0];
        ari_pkg::MUL_RC: b_q <= acc_q[PW-1:0];
        default:         p_q <= acc_q;
      endcase
    end
  end

  // ---------------- numerator and denominator ----------------
  logic          neg_q, undef_q;
  logic [DW-1:0] num_q, den_q, twob;
  logic [PW-1:0] diff;
  logic          a_lt_b;

  assign a_lt_b = a_q < b_q;
  assign diff   = a_lt_b ? (b_q - a_q) : (a_q - b_q);
  assign twob   = {b_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      neg_q   <= a_lt_b;
      num_q   <= {diff, 1'b0};
      den_q   <= p_q - twob;
      undef_q <= (p_q <= twob);
    end
  end

  // ---------------- restoring divider, one quotient bit a cycle ----------------
  localparam logic [QW:0] Cap = (QW+1)'(1) << (QW - 1);

  logic [RW-1:0] rem_q, rem_sh;
  logic [XW-1:0] dvd_q;
  logic [QW-1:0] quo_q;
  logic [QW:0]   quo_n;
  logic          qbit;

  assign rem_sh = {rem_q[RW-2:0], dvd_q[XW-1]};
  assign qbit   = rem_sh >= RW'(den_q);

  always_comb begin
    quo_n = {quo_q, qbit};
    if (quo_n > Cap) quo_n = Cap;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= '0;
      dvd_q <= {num_q, {FRACTION_BITS{1'b0}}};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? (rem_sh - RW'(den_q)) : rem_sh;
      dvd_q <= {dvd_q[XW-2:0], 1'b0};
      quo_q <= quo_n[QW-1:0];
    end
  end

  // ---------------- result register ----------------
  localparam logic [QW-1:0] NegLim = QW'(1) << (OW - 1);
  localparam logic [QW-1:0] PosLim = NegLim - QW'(1);

  logic [OW-1:0] res_val;
  logic [QW-1:0] mag;
  logic          out_valid_q;

  always_comb begin
    mag = quo_q;
    if (neg_q) begin
      if (mag > NegLim) mag = NegLim;
      res_val = OW'(0) - mag[OW-1:0];
    end else begin
      if (mag > PosLim) mag = PosLim;
      res_val = mag[OW-1:0];
    end
    if (undef_q) res_val = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      index_value_o    <= res_val;
      undefined_flag_o <= undef_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------- status ----------------
  assign sts_o.col_last  = col_last;
  assign sts_o.row_last  = row_last;
  assign sts_o.walk_last = cnt_q == CW'(ncols - NW'(1));
  assign sts_o.mul_last  = cnt_q == CW'(AW - 1);
  assign sts_o.div_last  = cnt_q == CW'(ITERS - 1);
  assign sts_o.undef     = undef_q;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

endmodule

FILE: rtl/core/adjusted_rand_index_engine.sv
// ----------------------------------------------------------------------------
// adjusted_rand_index_engine
// Adjusted Rand index of a contingency table streamed in row-major order.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// s_axis    in         tvalid/tready          tdata[COUNT_BITS-1:0] cell_count
// m_axis    out        tvalid/tready          tdata[31:0] index_value (Q2.30)
//                                             tuser[0]    undefined_flag
// apb       in         psel/penable/pready    0x0 rows_in_use, 0x4 cols_in_use
//
// Sequence: cells are taken while the block is idle; a cell that closes a row
//   is followed by the row pair update, during which intake stalls. After the
//   last cell the block walks the column store (read, then accumulate, per
//   column), forms the total pairs and runs the serial multiplier three times
//   over an AW-bit multiplier (AW = 2*COUNT_BITS + 4*log2(MAX_CLUSTERS), 56
//   bits by default); it then sets up numerator and denominator, divides,
//   one quotient bit a cycle, unless the result is undefined, and loads the result.
// Reset clears all control state, the sums and the column store valid bits;
//   no clearing pass is needed.
// A waiting result does not block intake of the next table; the result
//   register only stalls the end of the following table.
//
module adjusted_rand_index_engine #(
  parameter int unsigned MAX_CLUSTERS  = ari_pkg::MaxClustersDef,
  parameter int unsigned COUNT_BITS    = ari_pkg::CountBitsDef,
  parameter int unsigned FRACTION_BITS = ari_pkg::FractionBitsDef,
  localparam int unsigned TDATA_W      = ((COUNT_BITS + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // cell stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [TDATA_W-1:0]           s_axis_tdata,   // cell_count
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [ari_pkg::OutW-1:0]     m_axis_tdata,   // index_value
  output logic                         m_axis_tuser,   // undefined_flag
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ari_pkg::PaddrW-1:0]   paddr,
  input  logic [ari_pkg::PdataW-1:0]   pwdata,
  output logic [ari_pkg::PdataW-1:0]   prdata,
  output logic                         pready
);

  // configuration registers, word addressed
  logic [ari_pkg::CfgW-1:0] rows_q, cols_q;
  logic                     reg_sel;
  logic                     cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ari_pkg::CfgW'(ari_pkg::CfgResetV);
      cols_q <= ari_pkg::CfgW'(ari_pkg::CfgResetV);
    end else if (cfg_wr) begin
      if (reg_sel == 1'(ari_pkg::RegRows)) rows_q <= pwdata[ari_pkg::CfgW-1:0];
      else                                 cols_q <= pwdata[ari_pkg::CfgW-1:0];
    end
  end

  always_comb begin
    if (reg_sel == 1'(ari_pkg::RegRows)) prdata = ari_pkg::PdataW'(rows_q);
    else                                 prdata = ari_pkg::PdataW'(cols_q);
  end

  ari_pkg::ari_cmd_t cmd;
  ari_pkg::ari_sts_t sts;

  ari_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ari_dp #(
    .MAX_CLUSTERS  (MAX_CLUSTERS),
    .COUNT_BITS    (COUNT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cell_count_i     (s_axis_tdata[COUNT_BITS-1:0]),
    .rows_i           (rows_q),
    .cols_i           (cols_q),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .index_value_o    (m_axis_tdata),
    .undefined_flag_o (m_axis_tuser)
  );

endmodule
